/* design/text_console_cursor_engine_assert.svh */
// Assertion macros shared by the text console cursor engine RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define TCCE_ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define TCCE_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define TCCE_ASSERT_PROP(label, clk, rst, prop, msg)
`define TCCE_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

/* design/tcce_pkg.sv */
// Types, constants and helpers shared by the text console cursor engine.
package tcce_pkg;

   localparam int COLS                    = 80;
   localparam int ROWS                    = 25;
   localparam int SCROLL_FIRST_SOURCE_ROW = 3;
   localparam int CELL_TOTAL              = ROWS * COLS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int ADDR_W = 11;
   localparam int PARAM_W = 16;

   typedef logic [ROW_W-1:0]   row_type;
   typedef logic [COL_W-1:0]   col_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [PARAM_W-1:0] param_type;
   typedef logic [15:0]        cell_type;

   localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;
   localparam logic [7:0] RESET_ATTR     = 8'd31;

   localparam param_type ERASE_TO_CURSOR = 16'd1;
   localparam param_type ERASE_ALL       = 16'd2;

   localparam row_type  LAST_ROW   = row_type'(ROWS - 1);
   localparam col_type  LAST_COL   = col_type'(COLS - 1);
   localparam addr_type LAST_CELL  = addr_type'(CELL_TOTAL - 1);
   localparam addr_type LAST_ROW_BASE = addr_type'((ROWS - 1) * COLS);
   localparam addr_type SCROLL_FIRST_CELL = addr_type'(SCROLL_FIRST_SOURCE_ROW * COLS);

   typedef enum logic [1:0] {
      OP_CHAR = 2'd0,
      OP_CSI  = 2'd1,
      OP_READ = 2'd2
   } opcode_type;

   typedef enum logic [3:0] {
      CMD_POSITION      = 4'd0,
      CMD_UP            = 4'd1,
      CMD_DOWN          = 4'd2,
      CMD_RIGHT         = 4'd3,
      CMD_LEFT          = 4'd4,
      CMD_ERASE_DISPLAY = 4'd5,
      CMD_ERASE_LINE    = 4'd6,
      CMD_SAVE          = 4'd7,
      CMD_RESTORE       = 4'd8,
      CMD_IGNORE        = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_FILL,
      ST_READ,
      ST_HOLD
   } state_type;

   // One input event as unpacked from the stream.
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_code;
      logic [3:0] command;
      logic [1:0] param_count;
      param_type  param_first;
      param_type  param_second;
      addr_type   read_index;
   } item_type;

   // Memory work that one event leaves for the sequencer.
   typedef struct packed {
      logic       wr_en;
      addr_type   wr_addr;
      logic [7:0] wr_char;
      logic       scroll;
      logic       fill_en;
      addr_type   fill_first;
      addr_type   fill_last;
      logic       rd_en;
      addr_type   rd_addr;
   } plan_type;

   // Write port of the cell memory.
   typedef struct packed {
      logic     en;
      addr_type addr;
      cell_type data;
   } ram_wr_type;

   function automatic addr_type cell_addr(row_type row, col_type col);
      cell_addr = addr_type'(32'(row) * COLS + 32'(col));
   endfunction

endpackage

/* design/tcce_cell_ram.sv */
// Character cell memory: one write port, one read port with registered data.
module tcce_cell_ram (
   input  logic                 clock,
   input  tcce_pkg::ram_wr_type wr,
   input  logic                 rd_en,
   input  tcce_pkg::addr_type   rd_addr,
   output tcce_pkg::cell_type   rd_data
);

   tcce_pkg::cell_type cell_mem [tcce_pkg::CELL_TOTAL];
   tcce_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cell_mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cell_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/tcce_cursor.sv */
// Cursor and saved cursor registers, and decoding of one event into cursor
// moves and memory work.
module tcce_cursor (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  tcce_pkg::item_type  item,
   output tcce_pkg::row_type   row,
   output tcce_pkg::col_type   col,
   output tcce_pkg::plan_type  plan
);

   tcce_pkg::row_type   row_ff, row_in, srow_ff, srow_in;
   tcce_pkg::col_type   col_ff, col_in, scol_ff, scol_in;
   tcce_pkg::param_type p0, p1, cnt, r_pos, c_pos;
   logic [16:0]         row_sum, col_sum;
   tcce_pkg::row_type   bs_row;
   tcce_pkg::col_type   bs_col;
   tcce_pkg::addr_type  row_base, cur_addr;

   always_comb begin
      p0 = (item.param_count > 2'd0) ? item.param_first : '0;
      p1 = (item.param_count > 2'd1) ? item.param_second : '0;
      cnt = (p0 != '0) ? p0 : tcce_pkg::param_type'(1);
      r_pos = (p0 != '0) ? p0 - tcce_pkg::param_type'(1) : '0;
      c_pos = (p1 != '0) ? p1 - tcce_pkg::param_type'(1) : '0;
      row_sum = 17'(cnt) + 17'(row_ff);
      col_sum = 17'(cnt) + 17'(col_ff);
      row_base = tcce_pkg::cell_addr(row_ff, '0);
      cur_addr = tcce_pkg::cell_addr(row_ff, col_ff);
      if (col_ff != '0) begin
         bs_row = row_ff;
         bs_col = col_ff - tcce_pkg::col_type'(1);
      end else if (row_ff != '0) begin
         bs_row = row_ff - tcce_pkg::row_type'(1);
         bs_col = tcce_pkg::LAST_COL;
      end else begin
         bs_row = row_ff;
         bs_col = col_ff;
      end
   end

   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      srow_in = srow_ff;
      scol_in = scol_ff;
      plan    = '0;
      // A scroll always ends by blanking the bottom row.
      plan.fill_first = tcce_pkg::LAST_ROW_BASE;
      plan.fill_last  = tcce_pkg::LAST_CELL;
      unique case (tcce_pkg::opcode_type'(item.opcode))
         tcce_pkg::OP_CHAR: begin
            if (item.char_code == tcce_pkg::CHAR_NEWLINE) begin
               if (row_ff == tcce_pkg::LAST_ROW) begin
                  plan.scroll  = 1'b1;
                  plan.fill_en = 1'b1;
               end else begin
                  row_in = row_ff + tcce_pkg::row_type'(1);
               end
            end else if (item.char_code == tcce_pkg::CHAR_RETURN) begin
               col_in = '0;
            end else if (item.char_code == tcce_pkg::CHAR_BACKSPACE) begin
               row_in        = bs_row;
               col_in        = bs_col;
               plan.wr_en    = 1'b1;
               plan.wr_addr  = tcce_pkg::cell_addr(bs_row, bs_col);
               plan.wr_char  = tcce_pkg::CHAR_BLANK;
            end else if (item.char_code >= tcce_pkg::CHAR_BLANK) begin
               plan.wr_en   = 1'b1;
               plan.wr_addr = cur_addr;
               plan.wr_char = item.char_code;
               if (col_ff == tcce_pkg::LAST_COL) begin
                  col_in = '0;
                  if (row_ff == tcce_pkg::LAST_ROW) begin
                     plan.scroll  = 1'b1;
                     plan.fill_en = 1'b1;
                  end else begin
                     row_in = row_ff + tcce_pkg::row_type'(1);
                  end
               end else begin
                  col_in = col_ff + tcce_pkg::col_type'(1);
               end
            end
         end
         tcce_pkg::OP_CSI: begin
            unique case (tcce_pkg::cmd_type'(item.command))
               tcce_pkg::CMD_POSITION: begin
                  row_in = (r_pos < tcce_pkg::param_type'(tcce_pkg::ROWS)) ?
                           r_pos[tcce_pkg::ROW_W-1:0] : tcce_pkg::LAST_ROW;
                  col_in = (c_pos < tcce_pkg::param_type'(tcce_pkg::COLS)) ?
                           c_pos[tcce_pkg::COL_W-1:0] : tcce_pkg::LAST_COL;
               end
               tcce_pkg::CMD_UP: begin
                  row_in = (cnt > tcce_pkg::param_type'(row_ff)) ? '0 :
                           row_ff - cnt[tcce_pkg::ROW_W-1:0];
               end
               tcce_pkg::CMD_DOWN: begin
                  row_in = (row_sum < 17'(tcce_pkg::ROWS)) ?
                           row_sum[tcce_pkg::ROW_W-1:0] : tcce_pkg::LAST_ROW;
               end
               tcce_pkg::CMD_RIGHT: begin
                  col_in = (col_sum < 17'(tcce_pkg::COLS)) ?
                           col_sum[tcce_pkg::COL_W-1:0] : tcce_pkg::LAST_COL;
               end
               tcce_pkg::CMD_LEFT: begin
                  col_in = (cnt > tcce_pkg::param_type'(col_ff)) ? '0 :
                           col_ff - cnt[tcce_pkg::COL_W-1:0];
               end
               tcce_pkg::CMD_ERASE_DISPLAY: begin
                  if (p0 == tcce_pkg::ERASE_ALL) begin
                     row_in          = '0;
                     col_in          = '0;
                     plan.fill_en    = 1'b1;
                     plan.fill_first = '0;
                     plan.fill_last  = tcce_pkg::LAST_CELL;
                  end
               end
               tcce_pkg::CMD_ERASE_LINE: begin
                  plan.fill_en = 1'b1;
                  if (p0 == tcce_pkg::ERASE_TO_CURSOR) begin
                     plan.fill_first = row_base;
                     plan.fill_last  = cur_addr;
                  end else if (p0 == tcce_pkg::ERASE_ALL) begin
                     plan.fill_first = row_base;
                     plan.fill_last  = tcce_pkg::cell_addr(row_ff, tcce_pkg::LAST_COL);
                  end else begin
                     plan.fill_first = cur_addr;
                     plan.fill_last  = tcce_pkg::cell_addr(row_ff, tcce_pkg::LAST_COL);
                  end
               end
               tcce_pkg::CMD_SAVE: begin
                  srow_in = row_ff;
                  scol_in = col_ff;
               end
               tcce_pkg::CMD_RESTORE: begin
                  row_in = (srow_ff > tcce_pkg::LAST_ROW) ? tcce_pkg::LAST_ROW : srow_ff;
                  col_in = (scol_ff > tcce_pkg::LAST_COL) ? tcce_pkg::LAST_COL : scol_ff;
               end
               default: begin
               end
            endcase
         end
         tcce_pkg::OP_READ: begin
            plan.rd_en   = (item.read_index < tcce_pkg::addr_type'(tcce_pkg::CELL_TOTAL));
            plan.rd_addr = item.read_index;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         srow_ff <= '0;
         scol_ff <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         srow_ff <= srow_in;
         scol_ff <= scol_in;
      end
   end

   assign row = row_ff;
   assign col = col_ff;

endmodule

/* design/text_console_cursor_engine.sv */
// Text console cursor engine top level: stream ports, sequencer and result register.
//
// The req channel carries one parsed console event per transfer: a character,
// a CSI command or a read of one cell. Every event produces exactly one
// transfer on the rsp channel with the cursor position after the event and,
// for a cell read, the attribute and character of that cell (zero otherwise).
// The csr channel writes the attribute byte used for written and blanked
// cells; it is always ready and should only be written while the block is idle.
// After reset the block blanks the cell memory with the reset attribute,
// one cell per cycle, and takes no events until that is done.
// A cell read passes through the registered read data of the memory before
// its result is ready. Erase line, erase display and a scroll work through
// the cells one at a time, since the cell memory takes only one write per
// cycle. A new event is accepted only once the previous one has finished
// and its result has gone to the output register.
// The result sits in an output register, so the engine finishes its work and
// frees req_tready even while the receiver stalls; only when a second result
// is ready before the first is taken does the engine wait for the receiver.
module text_console_cursor_engine (
   input  logic        clock,
   input  logic        reset,
   // Event input.
   input  logic        req_tvalid,
   output logic        req_tready,
   // From bit 0: char_code[7:0], command[11:8], param_count[13:12],
   // param_first[29:14], param_second[45:30], read_index[56:46], zeros above.
   input  logic [63:0] req_tdata,
   // opcode[1:0].
   input  logic [1:0]  req_tuser,
   // Result output.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // From bit 0: cursor_row[4:0], cursor_col[11:5], cell_word[27:12], zeros above.
   output logic [31:0] rsp_tdata,
   // Attribute register write.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   `include "text_console_cursor_engine_assert.svh"

   tcce_pkg::state_type  state_ff, state_in;
   tcce_pkg::addr_type   cnt_ff, cnt_in;
   logic                 pend_ff, pend_in;
   tcce_pkg::addr_type   pend_addr_ff, pend_addr_in;
   tcce_pkg::cell_type   word_ff, word_in;
   tcce_pkg::plan_type   plan_ff;
   logic [7:0]           attr_ff;
   logic                 rsp_tvalid_ff;
   tcce_pkg::row_type    rsp_row_ff;
   tcce_pkg::col_type    rsp_col_ff;
   tcce_pkg::cell_type   rsp_word_ff;

   tcce_pkg::item_type   item;
   tcce_pkg::plan_type   plan;
   tcce_pkg::row_type    cur_row;
   tcce_pkg::col_type    cur_col;
   tcce_pkg::ram_wr_type ram_wr;
   logic                 ram_rd_en;
   tcce_pkg::addr_type   ram_rd_addr;
   tcce_pkg::cell_type   ram_rd_data;

   logic                 accept;
   logic                 out_free;
   logic                 finish;
   tcce_pkg::cell_type   finish_word;
   logic                 load_rsp;
   tcce_pkg::cell_type   blank_cell;

   // Unpack the event.
   always_comb begin
      item.opcode       = req_tuser;
      item.char_code    = req_tdata[7:0];
      item.command      = req_tdata[11:8];
      item.param_count  = req_tdata[13:12];
      item.param_first  = req_tdata[29:14];
      item.param_second = req_tdata[45:30];
      item.read_index   = req_tdata[56:46];
   end

   assign req_tready = (state_ff == tcce_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign blank_cell = {attr_ff, tcce_pkg::CHAR_BLANK};
   assign csr_ready  = 1'b1;

   // The cursor is committed at the transfer; the memory work follows.
   tcce_cursor u_cursor (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .row    (cur_row),
      .col    (cur_col),
      .plan   (plan)
   );

   tcce_cell_ram u_cell_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Sequencer. During a scroll each cell read in one cycle is written one
   // row higher in the next, so the copy runs through the memory in address
   // order and never overwrites a cell it still has to read.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      word_in      = word_ff;
      ram_wr       = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cnt_ff;
      finish       = 1'b0;
      finish_word  = '0;
      load_rsp     = 1'b0;

      // A copied cell waiting to be written has the write port first.
      if (pend_ff) begin
         ram_wr.en   = 1'b1;
         ram_wr.addr = pend_addr_ff;
         ram_wr.data = ram_rd_data;
      end

      unique case (state_ff)
         tcce_pkg::ST_CLEAR: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = cnt_ff;
            ram_wr.data = {tcce_pkg::RESET_ATTR, tcce_pkg::CHAR_BLANK};
            if (cnt_ff == tcce_pkg::LAST_CELL) begin
               state_in = tcce_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + tcce_pkg::addr_type'(1);
            end
         end
         tcce_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = tcce_pkg::ST_EXEC;
            end
         end
         tcce_pkg::ST_EXEC: begin
            if (plan_ff.wr_en) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = plan_ff.wr_addr;
               ram_wr.data = {attr_ff, plan_ff.wr_char};
            end
            if (plan_ff.scroll) begin
               state_in = tcce_pkg::ST_COPY;
               cnt_in   = tcce_pkg::SCROLL_FIRST_CELL;
            end else if (plan_ff.fill_en) begin
               state_in = tcce_pkg::ST_FILL;
               cnt_in   = plan_ff.fill_first;
            end else if (plan_ff.rd_en) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = plan_ff.rd_addr;
               state_in    = tcce_pkg::ST_READ;
            end else begin
               finish = 1'b1;
            end
         end
         tcce_pkg::ST_COPY: begin
            ram_rd_en    = 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = cnt_ff - tcce_pkg::addr_type'(tcce_pkg::COLS);
            if (cnt_ff == tcce_pkg::LAST_CELL) begin
               state_in = tcce_pkg::ST_FILL;
               cnt_in   = plan_ff.fill_first;
            end else begin
               cnt_in = cnt_ff + tcce_pkg::addr_type'(1);
            end
         end
         tcce_pkg::ST_FILL: begin
            if (!pend_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = cnt_ff;
               ram_wr.data = blank_cell;
               if (cnt_ff == plan_ff.fill_last) begin
                  finish = 1'b1;
               end else begin
                  cnt_in = cnt_ff + tcce_pkg::addr_type'(1);
               end
            end
         end
         tcce_pkg::ST_READ: begin
            finish      = 1'b1;
            finish_word = ram_rd_data;
         end
         tcce_pkg::ST_HOLD: begin
            finish      = 1'b1;
            finish_word = word_ff;
         end
         default: begin
            state_in = tcce_pkg::ST_IDLE;
         end
      endcase

      // Hand the result to the output register, or park it while the
      // previous result has not yet been taken.
      if (finish) begin
         if (out_free) begin
            load_rsp = 1'b1;
            state_in = tcce_pkg::ST_IDLE;
         end else begin
            word_in  = finish_word;
            state_in = tcce_pkg::ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcce_pkg::ST_CLEAR;
         cnt_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      word_ff      <= word_in;
      if (accept) begin
         plan_ff <= plan;
      end
   end

   // Attribute register.
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcce_pkg::RESET_ATTR;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_data;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_row_ff  <= cur_row;
         rsp_col_ff  <= cur_col;
         rsp_word_ff <= finish_word;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0, rsp_word_ff, rsp_col_ff, rsp_row_ff};

   // An accepted event always starts its memory step in the next cycle.
   `TCCE_ASSERT_PROP(a_accept_exec, clock, reset, accept |=> state_ff == tcce_pkg::ST_EXEC, "accepted event did not start execution")
   // A parked result exists only while the output register is occupied.
   `TCCE_ASSERT_PROP(a_hold_busy, clock, reset, state_ff == tcce_pkg::ST_HOLD |-> rsp_tvalid_ff, "result parked with a free output register")
   // Every memory write stays inside the cell array.
   `TCCE_ASSERT_NEVER(a_wr_range, clock, reset, ram_wr.en && ram_wr.addr > tcce_pkg::LAST_CELL, "cell write out of range")
   // The cursor always lies on the screen.
   `TCCE_ASSERT_NEVER(a_cursor_range, clock, reset, cur_row > tcce_pkg::LAST_ROW || cur_col > tcce_pkg::LAST_COL, "cursor off screen")

endmodule

/* sim/text_console_cursor_engine_tb.sv */
// Self-checking testbench for the text console cursor engine: directed table, then random events.
module text_console_cursor_engine_tb;

   // The run is cut short here; the slowest legal run stays far below it.
   localparam int CYCLE_LIMIT   = 8_000_000;
   localparam int RANDOM_EVENTS = 900;
   localparam int PHASES        = 6;
   // Cycles left after the last result so that a stray extra result is still seen.
   localparam int SETTLE_CYCLES = 40;
   localparam int PRINT_CAP     = 40;

   // Codes outside the defined sets, used to check that they are ignored.
   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam logic [3:0] CMD_UNUSED_TOP = 4'hF;

   // Cursor and cell word that one event is expected to report.
   typedef struct {
      tcce_pkg::row_type  row;
      tcce_pkg::col_type  col;
      tcce_pkg::cell_type word;
   } cursor_report_type;

   // One row of the directed table. Rows with fixed_result set carry a
   // typed-in result; the others are checked against the predictor.
   typedef struct {
      tcce_pkg::item_type ev;
      bit                 fixed_result;
      cursor_report_type  want;
   } drill_step_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = '0;

   text_console_cursor_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow copy of the console: cell buffer, cursor, saved cursor and attribute.
   tcce_pkg::cell_type screen [tcce_pkg::CELL_TOTAL];
   tcce_pkg::row_type  cur_row;
   tcce_pkg::col_type  cur_col;
   tcce_pkg::row_type  mark_row;
   tcce_pkg::col_type  mark_col;
   logic [7:0]         attr_now;

   cursor_report_type cursor_reports_due [$];
   drill_step_type    drill [$];

   int unsigned cycle_count  = 0;
   int          mismatches   = 0;
   int          results_seen = 0;
   int          events_sent  = 0;
   int          scrolls      = 0;
   int          clears       = 0;
   int          settings     = 0;
   int          stall_left   = 0;
   // quiet turns off all idling for the closing phase; calm gives stretches without it.
   bit          quiet        = 1'b0;
   bit          calm         = 1'b0;

   task automatic report_mismatch(string msg);
      if (mismatches < PRINT_CAP)
         $display("MISMATCH at result %0d: %s", results_seen, msg);
      mismatches++;
   endtask

   function automatic void paint(int r, int c, logic [7:0] ch);
      screen[r * tcce_pkg::COLS + c] = {attr_now, ch};
   endfunction

   // Newline behavior: step down, or at the bottom row scroll everything
   // from the first scrolling source row upward by one and blank the last row.
   function automatic void line_feed();
      if (int'(cur_row) + 1 >= tcce_pkg::ROWS) begin
         for (int r = tcce_pkg::SCROLL_FIRST_SOURCE_ROW; r < tcce_pkg::ROWS; r++)
            for (int c = 0; c < tcce_pkg::COLS; c++)
               screen[(r - 1) * tcce_pkg::COLS + c] = screen[r * tcce_pkg::COLS + c];
         for (int c = 0; c < tcce_pkg::COLS; c++)
            paint(tcce_pkg::ROWS - 1, c, tcce_pkg::CHAR_BLANK);
         scrolls++;
      end else begin
         cur_row = cur_row + 1'b1;
      end
   endfunction

   // Applies one event to the shadow console and returns the cell word it reports.
   function automatic tcce_pkg::cell_type console_step(tcce_pkg::item_type ev);
      int                 p0, p1, n, r, c, lo, hi;
      tcce_pkg::cell_type word;
      word = '0;
      // Parameters beyond param_count count as zero.
      p0 = (ev.param_count > 0) ? int'(ev.param_first) : 0;
      p1 = (ev.param_count > 1) ? int'(ev.param_second) : 0;
      n  = (p0 > 0) ? p0 : 1;
      case (ev.opcode)
         tcce_pkg::OP_CHAR: begin
            if (ev.char_code == tcce_pkg::CHAR_NEWLINE) begin
               line_feed();
            end else if (ev.char_code == tcce_pkg::CHAR_RETURN) begin
               cur_col = '0;
            end else if (ev.char_code == tcce_pkg::CHAR_BACKSPACE) begin
               // Steps back across rows, stays at home, and always blanks the cell.
               if (cur_col > 0) begin
                  cur_col = cur_col - 1'b1;
               end else if (cur_row > 0) begin
                  cur_row = cur_row - 1'b1;
                  cur_col = tcce_pkg::LAST_COL;
               end
               paint(int'(cur_row), int'(cur_col), tcce_pkg::CHAR_BLANK);
            end else if (ev.char_code >= tcce_pkg::CHAR_BLANK) begin
               paint(int'(cur_row), int'(cur_col), ev.char_code);
               if (cur_col == tcce_pkg::LAST_COL) begin
                  cur_col = '0;
                  line_feed();
               end else begin
                  cur_col = cur_col + 1'b1;
               end
            end
         end
         tcce_pkg::OP_CSI: begin
            case (tcce_pkg::cmd_type'(ev.command))
               tcce_pkg::CMD_POSITION: begin
                  r = (p0 > 0) ? p0 - 1 : 0;
                  c = (p1 > 0) ? p1 - 1 : 0;
                  cur_row = tcce_pkg::row_type'((r < tcce_pkg::ROWS) ? r : tcce_pkg::ROWS - 1);
                  cur_col = tcce_pkg::col_type'((c < tcce_pkg::COLS) ? c : tcce_pkg::COLS - 1);
               end
               tcce_pkg::CMD_UP: begin
                  cur_row = tcce_pkg::row_type'((n > int'(cur_row)) ? 0 : int'(cur_row) - n);
               end
               tcce_pkg::CMD_DOWN: begin
                  r = int'(cur_row) + n;
                  cur_row = tcce_pkg::row_type'((r < tcce_pkg::ROWS) ? r : tcce_pkg::ROWS - 1);
               end
               tcce_pkg::CMD_RIGHT: begin
                  c = int'(cur_col) + n;
                  cur_col = tcce_pkg::col_type'((c < tcce_pkg::COLS) ? c : tcce_pkg::COLS - 1);
               end
               tcce_pkg::CMD_LEFT: begin
                  cur_col = tcce_pkg::col_type'((n > int'(cur_col)) ? 0 : int'(cur_col) - n);
               end
               tcce_pkg::CMD_ERASE_DISPLAY: begin
                  if (p0 == int'(tcce_pkg::ERASE_ALL)) begin
                     for (int i = 0; i < tcce_pkg::CELL_TOTAL; i++)
                        screen[i] = {attr_now, tcce_pkg::CHAR_BLANK};
                     cur_row = '0;
                     cur_col = '0;
                     clears++;
                  end
               end
               tcce_pkg::CMD_ERASE_LINE: begin
                  if (p0 == int'(tcce_pkg::ERASE_TO_CURSOR)) begin
                     lo = 0;
                     hi = int'(cur_col) + 1;
                  end else if (p0 == int'(tcce_pkg::ERASE_ALL)) begin
                     lo = 0;
                     hi = tcce_pkg::COLS;
                  end else begin
                     lo = int'(cur_col);
                     hi = tcce_pkg::COLS;
                  end
                  for (c = lo; c < hi; c++)
                     paint(int'(cur_row), c, tcce_pkg::CHAR_BLANK);
               end
               tcce_pkg::CMD_SAVE: begin
                  mark_row = cur_row;
                  mark_col = cur_col;
               end
               tcce_pkg::CMD_RESTORE: begin
                  cur_row = (mark_row < tcce_pkg::ROWS) ? mark_row : tcce_pkg::LAST_ROW;
                  cur_col = (mark_col < tcce_pkg::COLS) ? mark_col : tcce_pkg::LAST_COL;
               end
               default: ;
            endcase
         end
         tcce_pkg::OP_READ: begin
            if (ev.read_index < tcce_pkg::CELL_TOTAL)
               word = screen[ev.read_index];
         end
         default: ;
      endcase
      return word;
   endfunction

   function automatic drill_step_type drill_row(logic [1:0] op, logic [7:0] ch,
                                                logic [3:0] cmd, logic [1:0] pc,
                                                tcce_pkg::param_type a,
                                                tcce_pkg::param_type b,
                                                tcce_pkg::addr_type idx, bit fixed_result,
                                                int r, int c, tcce_pkg::cell_type w);
      drill_step_type s;
      s.ev.opcode       = op;
      s.ev.char_code    = ch;
      s.ev.command      = cmd;
      s.ev.param_count  = pc;
      s.ev.param_first  = a;
      s.ev.param_second = b;
      s.ev.read_index   = idx;
      s.fixed_result    = fixed_result;
      s.want.row        = tcce_pkg::row_type'(r);
      s.want.col        = tcce_pkg::col_type'(c);
      s.want.word       = w;
      return s;
   endfunction

   // Parameter values: erase modes, small counts, screen-sized values, or anything.
   function automatic tcce_pkg::param_type pick_param();
      case ($urandom_range(0, 3))
         0:       return tcce_pkg::param_type'($urandom_range(0, 3));
         1:       return tcce_pkg::param_type'($urandom_range(0, 30));
         2:       return tcce_pkg::param_type'($urandom_range(0, 90));
         default: return tcce_pkg::param_type'($urandom);
      endcase
   endfunction

   // Random event. Every field is filled at random first so that unused
   // fields toggle too; the fields that matter are then shaped by operation.
   function automatic tcce_pkg::item_type random_event();
      tcce_pkg::item_type ev;
      int                 pick, base;
      ev.opcode       = tcce_pkg::OP_CHAR;
      ev.char_code    = 8'($urandom);
      ev.command      = 4'($urandom);
      ev.param_count  = 2'($urandom);
      ev.param_first  = 16'($urandom);
      ev.param_second = 16'($urandom);
      ev.read_index   = 11'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
         ev.char_code = 8'($urandom_range(int'(tcce_pkg::CHAR_BLANK), 255));
      end else if (pick < 52) begin
         case ($urandom_range(0, 3))
            0:       ev.char_code = tcce_pkg::CHAR_NEWLINE;
            1:       ev.char_code = tcce_pkg::CHAR_RETURN;
            2:       ev.char_code = tcce_pkg::CHAR_BACKSPACE;
            default: ev.char_code = 8'($urandom_range(0, int'(tcce_pkg::CHAR_BLANK) - 1));
         endcase
      end else if (pick < 78) begin
         ev.opcode = tcce_pkg::OP_CSI;
         ev.command = ($urandom_range(0, 9) == 0) ?
                      4'($urandom_range(int'(tcce_pkg::CMD_IGNORE), 15)) :
                      4'($urandom_range(0, int'(tcce_pkg::CMD_RESTORE)));
         ev.param_first  = pick_param();
         ev.param_second = pick_param();
      end else if (pick < 97) begin
         ev.opcode = tcce_pkg::OP_READ;
         case ($urandom_range(0, 9))
            0:       ev.read_index = 11'($urandom);
            1, 2:    ev.read_index = 11'($urandom_range(0, tcce_pkg::SCROLL_FIRST_SOURCE_ROW *
                                                           tcce_pkg::COLS - 1));
            default: begin
               // Mostly just behind the cursor, where recent writes landed.
               base = int'(cur_row) * tcce_pkg::COLS + int'(cur_col) - $urandom_range(0, 8);
               ev.read_index = 11'((base < 0) ? 0 : base);
            end
         endcase
      end else begin
         ev.opcode = OP_UNUSED;
      end
      return ev;
   endfunction

   // Offers one event, holds it until the transfer, then records what it must report.
   task automatic send_event(tcce_pkg::item_type ev, bit fixed_result,
                             cursor_report_type fixed_want);
      cursor_report_type  want;
      tcce_pkg::cell_type word;
      req_tvalid <= 1'b1;
      req_tuser  <= ev.opcode;
      req_tdata  <= {7'b0, ev.read_index, ev.param_second, ev.param_first,
                     ev.param_count, ev.command, ev.char_code};
      do @(posedge clock); while (!req_tready);
      word = console_step(ev);
      if (fixed_result) begin
         want = fixed_want;
      end else begin
         want.row  = cur_row;
         want.col  = cur_col;
         want.word = word;
      end
      cursor_reports_due.push_back(want);
      events_sent++;
   endtask

   // Now and then drops req_tvalid between events.
   task automatic pause_sender();
      int gap;
      if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits for every awaited result, then lets the engine settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (cursor_reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_attribute(logic [7:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      attr_now = value;
      settings++;
   endtask

   // Receiver: now and then holds rsp_tready low for a burst, never in the closing phase.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every result transfer is compared with the oldest awaited report.
   always @(posedge clock) begin : check_results
      cursor_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (cursor_reports_due.size() == 0) begin
            report_mismatch($sformatf("result with nothing awaited, tdata %h", rsp_tdata));
         end else begin
            want = cursor_reports_due.pop_front();
            if (rsp_tdata[4:0] !== want.row)
               report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                         rsp_tdata[4:0], want.row));
            if (rsp_tdata[11:5] !== want.col)
               report_mismatch($sformatf("cursor_col %0d, expected %0d",
                                         rsp_tdata[11:5], want.col));
            if (rsp_tdata[27:12] !== want.word)
               report_mismatch($sformatf("cell_word %h, expected %h",
                                         rsp_tdata[27:12], want.word));
            if (rsp_tdata[31:28] !== 4'b0)
               report_mismatch($sformatf("padding bits %b, expected zero", rsp_tdata[31:28]));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still awaited",
                  cycle_count, cursor_reports_due.size());
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : run
      cursor_report_type  none;
      int                 per_phase;
      tcce_pkg::cell_type reset_cell;
      none       = '{row: '0, col: '0, word: '0};
      per_phase  = RANDOM_EVENTS / PHASES;
      reset_cell = {tcce_pkg::RESET_ATTR, tcce_pkg::CHAR_BLANK};
      for (int i = 0; i < tcce_pkg::CELL_TOTAL; i++)
         screen[i] = reset_cell;
      cur_row  = '0;
      cur_col  = '0;
      mark_row = '0;
      mark_col = '0;
      attr_now = tcce_pkg::RESET_ATTR;

      // Directed table. Columns: opcode, char, command, param count, first and
      // second parameter, read index, typed-in result flag, row, col, cell word.
      drill.push_back(drill_row(tcce_pkg::OP_READ, 8'h00, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h0, 16'h0, 11'd0, 1'b1, 0, 0, reset_cell));
      drill.push_back(drill_row(tcce_pkg::OP_READ, 8'hFF, CMD_UNUSED_TOP, 2'd3,
                                16'hFFFF, 16'hFFFF, tcce_pkg::LAST_CELL, 1'b1, 0, 0,
                                reset_cell));
      // A read past the last cell reports zero.
      drill.push_back(drill_row(tcce_pkg::OP_READ, 8'h00, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h0, 16'h0, 11'h7FF, 1'b1, 0, 0, 16'h0));
      // The unused opcode changes nothing.
      drill.push_back(drill_row(OP_UNUSED, 8'h41, tcce_pkg::CMD_ERASE_DISPLAY, 2'd1,
                                tcce_pkg::ERASE_ALL, 16'h0, 11'd0, 1'b1, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, 8'h41, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h0, 16'h0, 11'd0, 1'b1, 0, 1, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, 8'hFF, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h0, 16'h0, 11'd0, 1'b1, 0, 2, 16'h0));
      // A control code with no meaning is dropped.
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, 8'h1B, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h0, 16'h0, 11'd0, 1'b1, 0, 2, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, tcce_pkg::CHAR_BACKSPACE,
                                tcce_pkg::CMD_POSITION, 2'd0, 16'h0, 16'h0,
                                11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_READ, 8'h00, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h0, 16'h0, 11'd0, 1'b0, 0, 0, 16'h0));
      // Position far past the screen clamps to the bottom right corner.
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_POSITION, 2'd2,
                                16'hFFFF, 16'hFFFF, 11'd0, 1'b1,
                                tcce_pkg::LAST_ROW, tcce_pkg::LAST_COL, 16'h0));
      // Printing in the corner wraps and scrolls.
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, 8'h5A, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h0, 16'h0, 11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_READ, 8'h00, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h0, 16'h0,
                                tcce_pkg::addr_type'(tcce_pkg::LAST_ROW_BASE - 1),
                                1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, tcce_pkg::CHAR_NEWLINE,
                                tcce_pkg::CMD_POSITION, 2'd0, 16'h0, 16'h0,
                                11'd0, 1'b0, 0, 0, 16'h0));
      // Position with no parameters homes the cursor; backspace at home stays.
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_POSITION, 2'd0,
                                16'h7, 16'h9, 11'd0, 1'b1, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, tcce_pkg::CHAR_BACKSPACE,
                                tcce_pkg::CMD_POSITION, 2'd0, 16'h0, 16'h0,
                                11'd0, 1'b0, 0, 0, 16'h0));
      // A count of zero moves by one, clamped at the top.
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_UP, 2'd1,
                                16'h0, 16'h0, 11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_DOWN, 2'd1,
                                16'hFFFF, 16'h0, 11'd0, 1'b1, tcce_pkg::LAST_ROW, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_RIGHT, 2'd3,
                                16'd5, 16'hFFFF, 11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_LEFT, 2'd1,
                                16'd2, 16'h0, 11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_SAVE, 2'd0,
                                16'h0, 16'h0, 11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_ERASE_LINE, 2'd1,
                                tcce_pkg::ERASE_TO_CURSOR, 16'h0,
                                11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_ERASE_LINE, 2'd2,
                                tcce_pkg::ERASE_ALL, 16'h3, 11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_ERASE_LINE, 2'd0,
                                tcce_pkg::ERASE_ALL, 16'h0, 11'd0, 1'b0, 0, 0, 16'h0));
      // Carriage return, then backspace from column zero to the row above.
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, tcce_pkg::CHAR_RETURN,
                                tcce_pkg::CMD_POSITION, 2'd0, 16'h0, 16'h0,
                                11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CHAR, tcce_pkg::CHAR_BACKSPACE,
                                tcce_pkg::CMD_POSITION, 2'd0, 16'h0, 16'h0,
                                11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_RESTORE, 2'd0,
                                16'h0, 16'h0, 11'd0, 1'b0, 0, 0, 16'h0));
      // Erase display only acts on mode two; then both ignored command codes.
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_ERASE_DISPLAY, 2'd1,
                                16'd3, 16'h0, 11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_ERASE_DISPLAY, 2'd2,
                                tcce_pkg::ERASE_ALL, 16'hFFFF, 11'd0, 1'b1, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, tcce_pkg::CMD_IGNORE, 2'd2,
                                16'd4, 16'd4, 11'd0, 1'b0, 0, 0, 16'h0));
      drill.push_back(drill_row(tcce_pkg::OP_CSI, 8'h00, CMD_UNUSED_TOP, 2'd2,
                                16'd4, 16'd4, 11'd0, 1'b0, 0, 0, 16'h0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The engine blanks its memory after reset; the first transfer waits for it.
      foreach (drill[i])
         send_event(drill[i].ev, drill[i].fixed_result, drill[i].want);
      drain();

      // Random phases, each under its own attribute; the last one runs without idling.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       write_attribute(8'h00);
            1:       write_attribute(8'hFF);
            default: write_attribute(8'($urandom));
         endcase
         quiet = (ph == PHASES - 1);
         for (int i = 0; i < per_phase; i++) begin
            if (i % 40 == 0)
               calm = ($urandom_range(0, 2) == 0);
            send_event(random_event(), 1'b0, none);
            pause_sender();
         end
         drain();
      end

      $display("Sent %0d console events under %0d attribute settings (%0d scrolls, %0d clears).",
               events_sent, settings + 1, scrolls, clears);
      $display("Checked %0d results, found %0d mismatches.", results_seen, mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
